// ===== sv/tso_pkg.sv =====
// shared types, constants and helpers for the tremolo sine oscillator
package tso_pkg;

  localparam int PHASE_W   = 32;
  localparam int TABLE_W   = 10;
  localparam int SAMPLE_W  = 16;
  localparam int CTRL_W    = 10;
  localparam int LEVEL_W   = 16;
  localparam int AMP_W     = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam int QUARTER_W    = TABLE_W - 2;
  localparam int FRAC_W       = 30;
  localparam int Z2_SHIFT     = FRAC_W - 2 * QUARTER_W;
  localparam int LEVEL_SHIFT  = FRAC_W + 1 - LEVEL_W;
  localparam int SAMPLE_SHIFT = 2 * FRAC_W + 2 - SAMPLE_W;

  localparam int MUL_W      = 32;
  localparam int DIGIT_W    = 8;
  localparam int DIGITS     = MUL_W / DIGIT_W;
  localparam int MUL_CNT_W  = $clog2(DIGITS);
  localparam int PROD_W     = 2 * MUL_W;
  localparam int MAG_W      = PROD_W - SAMPLE_SHIFT;
  localparam int DIVIDEND_W = CTRL_W + MUL_W;
  localparam int DIV_CNT_W  = $clog2(MUL_W);

  localparam logic [CTRL_W-1:0] DIVISOR = {CTRL_W{1'b1}};

  localparam logic [MUL_W-1:0] Q30_ONE = MUL_W'(64'd1073741824);
  localparam logic [MUL_W-1:0] SIN_A   = MUL_W'(64'd1686629713);
  localparam logic [MUL_W-1:0] SIN_B   = MUL_W'(64'd688904866);
  localparam logic [MUL_W-1:0] SIN_C   = MUL_W'(64'd76016977);

  localparam logic [QUARTER_W:0] X_FULL = {1'b1, {QUARTER_W{1'b0}}};

  localparam logic [MAG_W-1:0] SMAX_MAG = MAG_W'({(SAMPLE_W-1){1'b1}});
  localparam logic [MAG_W-1:0] SMIN_MAG = MAG_W'({1'b1, {(SAMPLE_W-1){1'b0}}});
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [PHASE_W-1:0] RST_TONE_STEP = PHASE_W'(64'd39370533);
  localparam logic [AMP_W-1:0]   RST_TONE_AMP  = AMP_W'(3277);
  localparam logic [PHASE_W-1:0] RST_LFO_MIN   = PHASE_W'(64'd89478);
  localparam logic [PHASE_W-1:0] RST_LFO_MAX   = PHASE_W'(64'd1789570);
  localparam logic [LEVEL_W-1:0] RST_THRESHOLD = LEVEL_W'(19661);
  localparam logic [PHASE_W-1:0] RST_LFO_STEP  = PHASE_W'(64'd178957);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_STEP = 3'd0,
    REG_TONE_AMP  = 3'd1,
    REG_LFO_MIN   = 3'd2,
    REG_LFO_MAX   = 3'd3,
    REG_THRESHOLD = 3'd4
  } tso_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_T1,
    ST_T2,
    ST_MAG,
    ST_LEVEL,
    ST_GAIN,
    ST_SCALE,
    ST_STEP,
    ST_DONE
  } tso_state_e;

  typedef struct packed {
    logic              control_valid;
    logic [CTRL_W-1:0] control_value;
    logic              block_end;
  } tso_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       crossing_valid;
    logic                       crossing_level;
  } tso_out_t;

  typedef struct packed {
    logic busy;
    logic last;
  } tso_unit_stat_t;

  // folded quarter-wave index of a phase, 0 .. 2^QUARTER_W
  function automatic logic [QUARTER_W:0] sine_x(input logic [PHASE_W-1:0] phase);
    logic [QUARTER_W-1:0] r;
    r = phase[PHASE_W-3 -: QUARTER_W];
    if (phase[PHASE_W-2]) begin
      sine_x = X_FULL - {1'b0, r};
    end else begin
      sine_x = {1'b0, r};
    end
  endfunction

endpackage

// ===== sv/tso_mul.sv =====
// digit-serial unsigned multiplier, one 8-bit digit of the second operand per cycle
module tso_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tso_pkg::MUL_W-1:0]     a_i,
  input  logic [tso_pkg::MUL_W-1:0]     b_i,
  output logic [tso_pkg::PROD_W-1:0]    prod_o,
  output tso_pkg::tso_unit_stat_t       stat_o
);
  import tso_pkg::*;

  localparam int SUM_W = MUL_W + DIGIT_W;

  logic                 busy_q, busy_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [MUL_W-1:0]     a_q;
  logic [MUL_W-1:0]     hi_q, lo_q;
  logic [SUM_W-1:0]     sum;

  assign sum = SUM_W'(hi_q) + SUM_W'(a_q) * SUM_W'(lo_q[DIGIT_W-1:0]);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = MUL_CNT_W'(DIGITS - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - MUL_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[SUM_W-1:DIGIT_W];
      lo_q <= {sum[DIGIT_W-1:0], lo_q[MUL_W-1:DIGIT_W]};
    end
  end

  assign prod_o      = {hi_q, lo_q};
  assign stat_o.busy = busy_q;
  assign stat_o.last = busy_q && (cnt_q == '0);

endmodule

// ===== sv/tso_div.sv =====
// bit-serial restoring divider by 1023, one quotient bit per cycle
module tso_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tso_pkg::DIVIDEND_W-1:0]  dividend_i,
  output logic [tso_pkg::MUL_W-1:0]       quot_o,
  output tso_pkg::tso_unit_stat_t         stat_o
);
  import tso_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CTRL_W-1:0]    rem_q;
  logic [MUL_W-1:0]     sh_q;
  logic [CTRL_W:0]      trial;
  logic                 ge;

  assign trial = {rem_q, sh_q[MUL_W-1]};
  assign ge    = trial >= {1'b0, DIVISOR};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(MUL_W - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // dividend bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DIVIDEND_W-1:MUL_W];
      sh_q  <= dividend_i[MUL_W-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? CTRL_W'(trial - {1'b0, DIVISOR}) : trial[CTRL_W-1:0];
      sh_q  <= {sh_q[MUL_W-2:0], ge};
    end
  end

  assign quot_o      = sh_q;
  assign stat_o.busy = busy_q;
  assign stat_o.last = busy_q && (cnt_q == '0);

endmodule

// ===== sv/tremolo_sine_oscillator.sv =====
// top level of the tremolo sine oscillator: sequencer, state and output register
//
// one request per audio sample tick on the input channel (valid/stall), one
// result per request on the output channel (valid/stall)
// a request may carry a control value that retunes the lfo rate, and may mark
// the end of a block, which triggers the threshold crossing check
// registers are written through cfg_we_i/cfg_index_i/cfg_data_i, and the
// user must write them only while idle: the block itself does not enforce it
// a request runs through the shared 8-bit digit-serial multiplier for nine
// products (eight without a control value) plus the idle, level, step and
// write states; no new request is taken until the sequencer is idle again
// the divide by 1023 runs alongside the sine products
// the result is written to the output register in the write state; the next
// request is taken while it waits there
// when the receiver stalls, a finished result holds in the sequencer until
// the output register frees, and no request is taken meanwhile
// reset clears both phases and the previous level, sets the lfo step and all
// registers to their defaults, and empties the output register
module tremolo_sine_oscillator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  tso_pkg::tso_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tso_pkg::tso_out_t                out_data_o,
  input  logic                             cfg_we_i,
  input  logic [tso_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tso_pkg::CFG_W-1:0]        cfg_data_i
);
  import tso_pkg::*;

  tso_state_e state_q, state_d;
  logic       issued_q, issued_d;
  logic       tone_q, tone_d;

  logic [PHASE_W-1:0] tone_step_q, lfo_min_q, lfo_max_q;
  logic [AMP_W-1:0]   tone_amp_q;
  logic [LEVEL_W-1:0] threshold_q;

  logic [PHASE_W-1:0] tone_phase_q, lfo_phase_q, lfo_step_q;
  logic [LEVEL_W-1:0] prev_level_q;

  tso_in_t            req_q;
  logic               diff_neg_q;
  logic [LEVEL_W-1:0] level_q;
  logic [FRAC_W:0]    m_q;

  logic     out_valid_q;
  tso_out_t out_q;

  logic                mul_start;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  tso_unit_stat_t      mul_stat;
  logic                mul_done;
  logic                is_mul_state;
  logic                div_start;
  logic [MUL_W-1:0]    div_q;
  tso_unit_stat_t      div_stat;

  logic                in_accept;
  logic                out_free;
  logic                out_write;

  logic [PHASE_W-1:0]  cur_phase;
  logic [QUARTER_W:0]  sx;
  logic [2*QUARTER_W+1:0] sxx;
  logic [MUL_W-1:0]    z2;
  logic [MUL_W-1:0]    t_val;
  logic [MUL_W-1:0]    diff_mag;
  logic [MUL_W-1:0]    m_raw;
  logic [FRAC_W:0]     m_clamp;
  logic [MUL_W-1:0]    lvl_sum;
  logic [MUL_W-LEVEL_SHIFT-1:0] lvl_wide;
  logic [LEVEL_W-1:0]  level_calc;
  logic [MAG_W-1:0]    mag;
  logic [SAMPLE_W-1:0] sample;
  logic                rise, fall;
  logic [PHASE_W-1:0]  step_new;

  tso_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_p),
    .stat_o  (mul_stat)
  );

  tso_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_p[DIVIDEND_W-1:0]),
    .quot_o     (div_q),
    .stat_o     (div_stat)
  );

  // datapath helpers
  assign cur_phase = tone_q ? tone_phase_q : lfo_phase_q;
  assign sx        = sine_x(cur_phase);
  assign sxx       = sx * sx;
  assign z2        = MUL_W'(sxx) << Z2_SHIFT;
  assign t_val     = mul_p[FRAC_W +: MUL_W];
  assign diff_mag  = diff_neg_q ? (lfo_min_q - lfo_max_q) : (lfo_max_q - lfo_min_q);
  assign m_raw     = mul_p[QUARTER_W +: MUL_W];
  assign m_clamp   = (m_raw > Q30_ONE) ? Q30_ONE[FRAC_W:0] : m_raw[FRAC_W:0];
  assign lvl_sum   = lfo_phase_q[PHASE_W-1] ? (Q30_ONE - MUL_W'(m_clamp))
                                            : (Q30_ONE + MUL_W'(m_clamp));
  assign lvl_wide  = lvl_sum[MUL_W-1:LEVEL_SHIFT];
  assign level_calc = lvl_wide[LEVEL_W] ? {LEVEL_W{1'b1}} : lvl_wide[LEVEL_W-1:0];

  assign mag = mul_p[PROD_W-1:SAMPLE_SHIFT];
  always_comb begin
    if (tone_phase_q[PHASE_W-1]) begin
      sample = (mag > SMIN_MAG) ? SAMPLE_MIN : SAMPLE_W'(~mag + MAG_W'(1));
    end else begin
      sample = (mag > SMAX_MAG) ? SAMPLE_MAX : SAMPLE_W'(mag);
    end
  end

  assign rise = req_q.block_end && (level_q >= threshold_q) && (prev_level_q < threshold_q);
  assign fall = req_q.block_end && !rise && (level_q <= threshold_q)
                && (prev_level_q > threshold_q);

  assign step_new = diff_neg_q ? (lfo_min_q - div_q) : (lfo_min_q + div_q);

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign mul_done  = issued_q && mul_stat.last;

  // next state
  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    tone_d   = tone_q;
    if (mul_start) begin
      issued_d = 1'b1;
    end
    if (mul_done) begin
      issued_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          tone_d  = 1'b0;
          state_d = in_data_i.control_valid ? ST_DIFF : ST_T1;
        end
      end
      ST_DIFF: begin
        if (mul_done) state_d = ST_T1;
      end
      ST_T1: begin
        if (mul_done) state_d = ST_T2;
      end
      ST_T2: begin
        if (mul_done) state_d = ST_MAG;
      end
      ST_MAG: begin
        if (mul_done) state_d = tone_q ? ST_GAIN : ST_LEVEL;
      end
      ST_LEVEL: begin
        tone_d  = 1'b1;
        state_d = ST_T1;
      end
      ST_GAIN: begin
        if (mul_done) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        if (mul_done) state_d = ST_STEP;
      end
      ST_STEP: begin
        if (!div_stat.busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o   = 1'b1;
    is_mul_state = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    out_write    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_DIFF: begin
        is_mul_state = 1'b1;
        mul_a        = diff_mag;
        mul_b        = MUL_W'(req_q.control_value);
      end
      ST_T1: begin
        is_mul_state = 1'b1;
        mul_a        = SIN_C;
        mul_b        = z2;
      end
      ST_T2: begin
        is_mul_state = 1'b1;
        mul_a        = SIN_B - t_val;
        mul_b        = z2;
      end
      ST_MAG: begin
        is_mul_state = 1'b1;
        mul_a        = SIN_A - t_val;
        mul_b        = MUL_W'(sx);
      end
      ST_GAIN: begin
        is_mul_state = 1'b1;
        mul_a        = MUL_W'(level_q);
        mul_b        = MUL_W'(tone_amp_q);
      end
      ST_SCALE: begin
        is_mul_state = 1'b1;
        mul_a        = mul_p[MUL_W-1:0];
        mul_b        = MUL_W'(m_q);
      end
      ST_DONE: begin
        out_write = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    mul_start = is_mul_state && !issued_q;
  end

  assign div_start = (state_q == ST_T1) && !issued_q && !tone_q && req_q.control_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      tone_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      tone_q   <= tone_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_step_q <= RST_TONE_STEP;
      tone_amp_q  <= RST_TONE_AMP;
      lfo_min_q   <= RST_LFO_MIN;
      lfo_max_q   <= RST_LFO_MAX;
      threshold_q <= RST_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TONE_STEP: tone_step_q <= cfg_data_i[PHASE_W-1:0];
        REG_TONE_AMP:  tone_amp_q  <= cfg_data_i[AMP_W-1:0];
        REG_LFO_MIN:   lfo_min_q   <= cfg_data_i[PHASE_W-1:0];
        REG_LFO_MAX:   lfo_max_q   <= cfg_data_i[PHASE_W-1:0];
        REG_THRESHOLD: threshold_q <= cfg_data_i[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // oscillator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_phase_q <= '0;
      lfo_phase_q  <= '0;
      lfo_step_q   <= RST_LFO_STEP;
      prev_level_q <= '0;
    end else begin
      if (state_q == ST_STEP && !div_stat.busy && req_q.control_valid) begin
        lfo_step_q <= step_new;
      end
      if (out_write) begin
        tone_phase_q <= tone_phase_q + tone_step_q;
        lfo_phase_q  <= lfo_phase_q + lfo_step_q;
        if (req_q.block_end) begin
          prev_level_q <= level_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q      <= in_data_i;
      diff_neg_q <= lfo_max_q < lfo_min_q;
    end
    if (state_q == ST_LEVEL) begin
      level_q <= level_calc;
    end
    if (state_q == ST_GAIN && !issued_q) begin
      m_q <= m_clamp;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_write) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_write) begin
      out_q.sample_out     <= sample;
      out_q.crossing_valid <= rise || fall;
      out_q.crossing_level <= rise;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_div_idle_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> !div_stat.busy)
    else $error("divider still busy when the result is written");

  a_mul_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier restarted while busy");

  a_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mul_stat.busy && !div_stat.busy)
    else $error("arithmetic unit busy while idle");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("output valid raised outside the write state");

  a_level_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.crossing_level && !out_q.crossing_valid))
    else $error("crossing level set without a crossing");

endmodule
